>>> sv/wtst_pkg.sv
// ----------------------------------------------------------------------------
// Windowed trade statistics package
// Shared types and constants of the windowed trade statistics table.
// ----------------------------------------------------------------------------
package wtst_pkg;

   localparam int TIME_W      = 48;
   localparam int WLEN_W      = 27;
   localparam int REM_W       = WLEN_W + 1;
   localparam int DIV_BITS    = 4;
   localparam int DIV_STEPS   = TIME_W / DIV_BITS;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int MAX_RESULTS = 32;
   localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1000);

   localparam logic [1:0] CMD_TRADE     = 2'd0;
   localparam logic [1:0] CMD_QUERY     = 2'd1;
   localparam logic [1:0] CMD_EXT_DONE  = 2'd2;
   localparam logic [1:0] CMD_EXT_ALL   = 2'd3;

   localparam logic [2:0] STS_ACCEPTED  = 3'd0;
   localparam logic [2:0] STS_DROPPED   = 3'd1;
   localparam logic [2:0] STS_FOUND     = 3'd2;
   localparam logic [2:0] STS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STS_RECORD    = 3'd4;
   localparam logic [2:0] STS_EMPTY     = 3'd5;

   typedef struct packed {
      logic [7:0]        symbol;
      logic [TIME_W-1:0] window_start;
      logic [31:0]       lo_price;
      logic [31:0]       hi_price;
      logic [31:0]       n_trades;
      logic [63:0]       notional;
      logic [31:0]       buyer_count;
      logic [31:0]       seller_count;
   } slot_type;

   // Search key broadcast to every cell. The window start doubles as the
   // extraction cutoff.
   typedef struct packed {
      logic [7:0]        symbol;
      logic [TIME_W-1:0] window_start;
      logic              take_all;
   } key_type;

   // Running search result that travels down the row of cells.
   typedef struct packed {
      logic              ext_ok;
      logic [7:0]        ext_symbol;
      logic [TIME_W-1:0] ext_window_start;
      logic              hit;
      logic              free_ok;
   } scan_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      sat_inc32 = (v == '1) ? v : v + 32'd1;
   endfunction

endpackage

>>> sv/wtst_cell.sv
// ----------------------------------------------------------------------------
// Windowed trade statistics cell
// Holds one table slot and folds it into the search result passed along.
// ----------------------------------------------------------------------------
module wtst_cell #(
   parameter int IDX_W = 5,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  wtst_pkg::key_type  key,
   input  wtst_pkg::scan_type scan_in,
   input  logic [IDX_W-1:0]   ext_idx_in,
   input  logic [IDX_W-1:0]   hit_idx_in,
   input  logic [IDX_W-1:0]   free_idx_in,
   output wtst_pkg::scan_type scan_out,
   output logic [IDX_W-1:0]   ext_idx_out,
   output logic [IDX_W-1:0]   hit_idx_out,
   output logic [IDX_W-1:0]   free_idx_out,
   input  logic               wr_en,
   input  logic               wr_clear,
   input  logic [IDX_W-1:0]   wr_idx,
   input  wtst_pkg::slot_type wr_data,
   output wtst_pkg::slot_type slot
);
   import wtst_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic             valid_ff;
   slot_type         slot_ff;
   scan_type         scan_ff, scan_in_c;
   logic [IDX_W-1:0] ext_idx_ff, hit_idx_ff, free_idx_ff;
   logic [IDX_W-1:0] ext_idx_in_c, hit_idx_in_c, free_idx_in_c;
   logic             match, eligible, smaller;

   always_comb begin
      match    = valid_ff && slot_ff.symbol == key.symbol &&
                 slot_ff.window_start == key.window_start;
      eligible = valid_ff && (key.take_all || slot_ff.window_start < key.window_start);
      smaller  = {slot_ff.symbol, slot_ff.window_start} <
                 {scan_in.ext_symbol, scan_in.ext_window_start};
      scan_in_c     = scan_in;
      ext_idx_in_c  = ext_idx_in;
      hit_idx_in_c  = hit_idx_in;
      free_idx_in_c = free_idx_in;
      if (eligible && (!scan_in.ext_ok || smaller)) begin
         scan_in_c.ext_ok           = 1'b1;
         scan_in_c.ext_symbol       = slot_ff.symbol;
         scan_in_c.ext_window_start = slot_ff.window_start;
         ext_idx_in_c               = MY_IDX;
      end
      if (!scan_in.hit && match) begin
         scan_in_c.hit = 1'b1;
         hit_idx_in_c  = MY_IDX;
      end
      if (!scan_in.free_ok && !valid_ff) begin
         scan_in_c.free_ok = 1'b1;
         free_idx_in_c     = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         scan_ff  <= '0;
      end else begin
         scan_ff <= scan_in_c;
         if (wr_en && wr_idx == MY_IDX) begin
            valid_ff <= !wr_clear;
         end
      end
      if (wr_en && !wr_clear && wr_idx == MY_IDX) begin
         slot_ff <= wr_data;
      end
      ext_idx_ff  <= ext_idx_in_c;
      hit_idx_ff  <= hit_idx_in_c;
      free_idx_ff <= free_idx_in_c;
   end

   assign scan_out     = scan_ff;
   assign ext_idx_out  = ext_idx_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;
   assign slot         = slot_ff;

endmodule

>>> sv/windowed_trade_stats_table_core.sv
// ----------------------------------------------------------------------------
// Windowed trade statistics table core
// Per-symbol tumbling-window trade statistics kept in a row of slot cells.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_*           beat taken when start and !busy
//   response  rsp_valid, rsp_*             one-cycle strobe, always taken
//   config    csr_valid, csr_ready, csr_*  beat taken when valid and ready
//
// Sequence: a trade first runs a remainder division (four bits per cycle) and
// then a search whose result ripples through the row of cells, one cell per
// cycle. A query runs one such search. An extraction runs one search per
// record found plus one final search. Reset clears the valid bits of all cells
// at once, so no clearing pass is needed. The receiver cannot stall the
// response; busy holds off the next request until the edge that puts the
// current request's last beat on the response ports, so the next request may
// be taken in that cycle.
//
module windowed_trade_stats_table_core #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_symbol_id,
   input  logic [47:0] req_time_ms,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   input  logic        req_buyer_is_maker,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_symbol,
   output logic [47:0] rsp_out_window_start,
   output logic [31:0] rsp_lo_price,
   output logic [31:0] rsp_hi_price,
   output logic [31:0] rsp_n_trades,
   output logic [63:0] rsp_notional,
   output logic [31:0] rsp_buyer_count,
   output logic [31:0] rsp_seller_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [26:0] csr_data
);
   import wtst_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN
   } state_type;

   state_type         state_ff;
   logic [1:0]        cmd_ff;
   logic [TIME_W-1:0] time_ff;
   logic [31:0]       price_ff, qty_ff;
   logic              seller_ff;
   logic [WLEN_W-1:0] window_len_ff;
   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff;
   logic [63:0]       prod_ff;
   key_type           key_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NCNT_W-1:0] n_ff;
   slot_type          pend_ff;
   logic              have_pend_ff;

   logic              rsp_valid_ff, rsp_last_ff;
   logic              rsp_valid_in;
   logic [2:0]        rsp_status_ff;
   slot_type          rsp_slot_ff;

   // Row of cells and its taps.
   scan_type          scan_w   [TABLE_ENTRIES];
   logic [IDX_W-1:0]  ext_idx_w [TABLE_ENTRIES];
   logic [IDX_W-1:0]  hit_idx_w [TABLE_ENTRIES];
   logic [IDX_W-1:0]  free_idx_w[TABLE_ENTRIES];
   slot_type          slot_w   [TABLE_ENTRIES];

   logic              wr_en_in, wr_clear_in;
   logic [IDX_W-1:0]  wr_idx_in;
   slot_type          wr_data_in;

   logic [WLEN_W-1:0] len_eff;
   logic              scan_done;
   scan_type          res;
   logic [IDX_W-1:0]  rd_idx;
   slot_type          rd_slot, merged, blank;
   logic [64:0]       sum;
   logic              ext_take;

   genvar k;
   generate
      for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
         if (k == 0) begin : g_first
            wtst_cell #(.IDX_W(IDX_W), .INDEX(k)) u_cell (
               .clock(clock), .reset(reset), .key(key_ff),
               .scan_in('0), .ext_idx_in('0), .hit_idx_in('0), .free_idx_in('0),
               .scan_out(scan_w[k]), .ext_idx_out(ext_idx_w[k]),
               .hit_idx_out(hit_idx_w[k]), .free_idx_out(free_idx_w[k]),
               .wr_en(wr_en_in), .wr_clear(wr_clear_in), .wr_idx(wr_idx_in),
               .wr_data(wr_data_in), .slot(slot_w[k])
            );
         end else begin : g_next
            wtst_cell #(.IDX_W(IDX_W), .INDEX(k)) u_cell (
               .clock(clock), .reset(reset), .key(key_ff),
               .scan_in(scan_w[k-1]), .ext_idx_in(ext_idx_w[k-1]),
               .hit_idx_in(hit_idx_w[k-1]), .free_idx_in(free_idx_w[k-1]),
               .scan_out(scan_w[k]), .ext_idx_out(ext_idx_w[k]),
               .hit_idx_out(hit_idx_w[k]), .free_idx_out(free_idx_w[k]),
               .wr_en(wr_en_in), .wr_clear(wr_clear_in), .wr_idx(wr_idx_in),
               .wr_data(wr_data_in), .slot(slot_w[k])
            );
         end
      end
   endgenerate

   // A window length of zero behaves as one.
   assign len_eff = (window_len_ff == '0) ? WLEN_W'(1) : window_len_ff;

   // Restoring remainder, four dividend bits per cycle, most significant first.
   always_comb begin
      logic [REM_W-1:0]  r;
      logic [TIME_W-1:0] d;
      r = rem_ff;
      d = dvd_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         r = {r[REM_W-2:0], d[TIME_W-1]};
         d = {d[TIME_W-2:0], 1'b0};
         if (r >= {1'b0, len_eff}) begin
            r = r - {1'b0, len_eff};
         end
      end
      rem_in = r;
      dvd_in = d;
   end

   // The last cell holds the finished search once the result has crossed the row.
   assign scan_done = (state_ff == ST_SCAN) && (cnt_ff == CNT_W'(TABLE_ENTRIES));
   assign res       = scan_w[TABLE_ENTRIES-1];
   assign ext_take  = res.ext_ok && (n_ff < NCNT_W'(MAX_RESULTS));

   // Every finished search sends a beat, except the first record of an
   // extraction, which is held back until the next search.
   assign rsp_valid_in = scan_done &&
                         ((cmd_ff == CMD_TRADE) || (cmd_ff == CMD_QUERY) ||
                          !ext_take || have_pend_ff);

   always_comb begin
      if (cmd_ff == CMD_EXT_DONE || cmd_ff == CMD_EXT_ALL) begin
         rd_idx = ext_idx_w[TABLE_ENTRIES-1];
      end else begin
         rd_idx = hit_idx_w[TABLE_ENTRIES-1];
      end
      rd_slot = slot_w[rd_idx];
   end

   // New slot contents for a trade. A freshly claimed slot starts from the
   // trade's own price and zero counters.
   always_comb begin
      slot_type base;
      if (res.hit) begin
         base = rd_slot;
      end else begin
         base              = '0;
         base.symbol       = key_ff.symbol;
         base.window_start = key_ff.window_start;
         base.lo_price     = price_ff;
         base.hi_price     = price_ff;
      end
      merged = base;
      if (price_ff < base.lo_price) merged.lo_price = price_ff;
      if (price_ff > base.hi_price) merged.hi_price = price_ff;
      merged.n_trades = sat_inc32(base.n_trades);
      sum = {1'b0, base.notional} + {1'b0, prod_ff};
      merged.notional = sum[64] ? '1 : sum[63:0];
      if (seller_ff) begin
         merged.seller_count = sat_inc32(base.seller_count);
      end else begin
         merged.buyer_count = sat_inc32(base.buyer_count);
      end

      blank              = '0;
      blank.symbol       = key_ff.symbol;
      blank.window_start = key_ff.window_start;
   end

   // Cell write port: trades write the merged slot, extraction frees the
   // slot that it reports.
   always_comb begin
      wr_en_in    = 1'b0;
      wr_clear_in = 1'b0;
      wr_idx_in   = hit_idx_w[TABLE_ENTRIES-1];
      wr_data_in  = merged;
      if (scan_done) begin
         case (cmd_ff)
            CMD_TRADE: begin
               wr_en_in = res.hit || res.free_ok;
               if (!res.hit) wr_idx_in = free_idx_w[TABLE_ENTRIES-1];
            end
            CMD_QUERY: begin
               wr_en_in = 1'b0;
            end
            default: begin
               wr_en_in    = ext_take;
               wr_clear_in = 1'b1;
               wr_idx_in   = ext_idx_w[TABLE_ENTRIES-1];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WLEN_RESET;
         rsp_valid_ff  <= 1'b0;
         have_pend_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  window_len_ff <= csr_data;
               end
               if (start) begin
                  cmd_ff       <= req_command;
                  time_ff      <= req_time_ms;
                  price_ff     <= req_price;
                  qty_ff       <= req_quantity;
                  seller_ff    <= req_buyer_is_maker;
                  dvd_ff       <= req_time_ms;
                  rem_ff       <= '0;
                  step_ff      <= '0;
                  cnt_ff       <= '0;
                  n_ff         <= '0;
                  have_pend_ff <= 1'b0;
                  key_ff       <= '{symbol: req_symbol_id, window_start: req_time_ms,
                                    take_all: (req_command == CMD_EXT_ALL)};
                  state_ff     <= (req_command == CMD_TRADE) ? ST_DIV : ST_SCAN;
               end
            end
            ST_DIV: begin
               dvd_ff  <= dvd_in;
               rem_ff  <= rem_in;
               prod_ff <= price_ff * qty_ff;
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  key_ff.window_start <= time_ff - {{(TIME_W-REM_W){1'b0}}, rem_in};
                  cnt_ff              <= '0;
                  state_ff            <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (!scan_done) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end else begin
                  case (cmd_ff)
                     CMD_TRADE: begin
                        rsp_last_ff <= 1'b1;
                        if (res.hit || res.free_ok) begin
                           rsp_status_ff <= STS_ACCEPTED;
                           rsp_slot_ff   <= merged;
                        end else begin
                           rsp_status_ff <= STS_DROPPED;
                           rsp_slot_ff   <= blank;
                        end
                        state_ff <= ST_IDLE;
                     end
                     CMD_QUERY: begin
                        rsp_last_ff <= 1'b1;
                        if (res.hit) begin
                           rsp_status_ff <= STS_FOUND;
                           rsp_slot_ff   <= rd_slot;
                        end else begin
                           rsp_status_ff <= STS_NOT_FOUND;
                           rsp_slot_ff   <= blank;
                        end
                        state_ff <= ST_IDLE;
                     end
                     default: begin
                        // A record is held back one search so that the last
                        // flag is known when it goes out.
                        if (ext_take) begin
                           if (have_pend_ff) begin
                              rsp_last_ff   <= 1'b0;
                              rsp_status_ff <= STS_RECORD;
                              rsp_slot_ff   <= pend_ff;
                           end
                           pend_ff      <= rd_slot;
                           have_pend_ff <= 1'b1;
                           n_ff         <= n_ff + NCNT_W'(1);
                           cnt_ff       <= '0;
                        end else begin
                           rsp_last_ff <= 1'b1;
                           if (have_pend_ff) begin
                              rsp_status_ff <= STS_RECORD;
                              rsp_slot_ff   <= pend_ff;
                           end else begin
                              rsp_status_ff <= STS_EMPTY;
                              rsp_slot_ff   <= '0;
                           end
                           have_pend_ff <= 1'b0;
                           state_ff     <= ST_IDLE;
                        end
                     end
                  endcase
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign csr_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_symbol       = rsp_slot_ff.symbol;
   assign rsp_out_window_start = rsp_slot_ff.window_start;
   assign rsp_lo_price         = rsp_slot_ff.lo_price;
   assign rsp_hi_price         = rsp_slot_ff.hi_price;
   assign rsp_n_trades         = rsp_slot_ff.n_trades;
   assign rsp_notional         = rsp_slot_ff.notional;
   assign rsp_buyer_count      = rsp_slot_ff.buyer_count;
   assign rsp_seller_count     = rsp_slot_ff.seller_count;
   assign rsp_last             = rsp_last_ff;

endmodule

>>> tb/sv/tb_windowed_trade_stats_table_core.sv
// ----------------------------------------------------------------------------
// Windowed trade statistics table testbench
// Drives trades, queries and extractions under several window lengths and
// checks every response beat against a scoreboard that mirrors the table.
// ----------------------------------------------------------------------------
module tb_windowed_trade_stats_table_core;
   import wtst_pkg::*;

   localparam int N_SLOTS     = 32;
   localparam int STALL_LIMIT = 3000;

   // One response beat, field for field as it leaves the block.
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  symbol;
      logic [47:0] window_start;
      logic [31:0] lo_price;
      logic [31:0] hi_price;
      logic [31:0] n_trades;
      logic [63:0] notional;
      logic [31:0] buyer_count;
      logic [31:0] seller_count;
      logic        last;
   } stats_beat_type;

   // Scoreboard: keeps its own copy of the window table and the queue of
   // response beats that the accepted requests must still produce.
   class window_table_scoreboard;
      logic [26:0]     win_len;
      bit              used[N_SLOTS];
      slot_type        slots[N_SLOTS];
      stats_beat_type  due_beats[$];
      int              mismatches;
      logic [7:0]      recent_symbol;
      logic [47:0]     recent_window;

      function new();
         win_len = WLEN_RESET;
         mismatches = 0;
         recent_symbol = '0;
         recent_window = '0;
         foreach (used[i]) used[i] = 0;
      endfunction

      function stats_beat_type blank_beat(logic [2:0] st, logic [7:0] sym,
                                          logic [47:0] ws);
         stats_beat_type b;
         b = '0;
         b.status = st;
         b.symbol = sym;
         b.window_start = ws;
         return b;
      endfunction

      function stats_beat_type slot_beat(logic [2:0] st, int s);
         stats_beat_type b;
         b = blank_beat(st, slots[s].symbol, slots[s].window_start);
         b.lo_price     = slots[s].lo_price;
         b.hi_price     = slots[s].hi_price;
         b.n_trades     = slots[s].n_trades;
         b.notional     = slots[s].notional;
         b.buyer_count  = slots[s].buyer_count;
         b.seller_count = slots[s].seller_count;
         return b;
      endfunction

      function int lookup(logic [7:0] sym, logic [47:0] ws);
         for (int i = 0; i < N_SLOTS; i++)
            if (used[i] && slots[i].symbol == sym && slots[i].window_start == ws)
               return i;
         return -1;
      endfunction

      function int outstanding();
         return due_beats.size();
      endfunction

      function void expect_beat(stats_beat_type b);
         due_beats.insert(due_beats.size(), b);
      endfunction

      function logic [31:0] sat_up(logic [31:0] v);
         return (v == '1) ? v : v + 32'd1;
      endfunction

      // Called for every request beat the block takes.
      function void note_request(logic [1:0] cmd, logic [7:0] sym, logic [47:0] t,
                                 logic [31:0] price, logic [31:0] qty, logic seller);
         logic [47:0] len;
         logic [47:0] ws;
         logic [63:0] prod;
         stats_beat_type b;
         int s;
         int best;
         int n;
         if (cmd == CMD_TRADE) begin
            // A zero window length behaves as one millisecond.
            len  = (win_len == 0) ? 48'd1 : 48'(win_len);
            ws   = t - (t % len);
            prod = 64'(price) * 64'(qty);
            recent_symbol = sym;
            recent_window = ws;
            s = lookup(sym, ws);
            if (s < 0) begin
               for (int i = 0; i < N_SLOTS; i++)
                  if (!used[i]) begin
                     s = i;
                     break;
                  end
               if (s < 0) begin
                  b = blank_beat(STS_DROPPED, sym, ws);
                  b.last = 1;
                  expect_beat(b);
                  return;
               end
               used[s] = 1;
               slots[s] = '0;
               slots[s].symbol = sym;
               slots[s].window_start = ws;
               slots[s].lo_price = price;
               slots[s].hi_price = price;
            end else begin
               if (price < slots[s].lo_price) slots[s].lo_price = price;
               if (price > slots[s].hi_price) slots[s].hi_price = price;
            end
            slots[s].n_trades = sat_up(slots[s].n_trades);
            slots[s].notional = (slots[s].notional > ~64'd0 - prod) ? ~64'd0
                                : slots[s].notional + prod;
            if (seller) slots[s].seller_count = sat_up(slots[s].seller_count);
            else        slots[s].buyer_count  = sat_up(slots[s].buyer_count);
            b = slot_beat(STS_ACCEPTED, s);
            b.last = 1;
            expect_beat(b);
         end else if (cmd == CMD_QUERY) begin
            s = lookup(sym, t);
            b = (s < 0) ? blank_beat(STS_NOT_FOUND, sym, t) : slot_beat(STS_FOUND, s);
            b.last = 1;
            expect_beat(b);
         end else begin
            // Extraction: lowest symbol first, then lowest window start.
            n = 0;
            while (n < MAX_RESULTS) begin
               best = -1;
               for (int i = 0; i < N_SLOTS; i++) begin
                  if (!used[i]) continue;
                  if (cmd == CMD_EXT_DONE && !(slots[i].window_start < t)) continue;
                  if (best < 0 || slots[i].symbol < slots[best].symbol ||
                      (slots[i].symbol == slots[best].symbol &&
                       slots[i].window_start < slots[best].window_start))
                     best = i;
               end
               if (best < 0) break;
               expect_beat(slot_beat(STS_RECORD, best));
               used[best] = 0;
               n++;
            end
            if (n == 0) begin
               b = blank_beat(STS_EMPTY, '0, '0);
               b.last = 1;
               expect_beat(b);
            end else begin
               due_beats[due_beats.size()-1].last = 1;
            end
         end
      endfunction

      function string show(stats_beat_type b);
         return $sformatf({"st=%0d sym=%0d ws=%0h min=%0h max=%0h cnt=%0d ",
                           "notional=%0h buy=%0d sell=%0d last=%0b"},
                          b.status, b.symbol, b.window_start, b.lo_price,
                          b.hi_price, b.n_trades, b.notional, b.buyer_count,
                          b.seller_count, b.last);
      endfunction

      // Called for every response beat; compares with the oldest expectation.
      function void check_beat(stats_beat_type got);
         stats_beat_type want;
         if (due_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: %s", show(got));
            return;
         end
         want = due_beats.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch");
               $display("  expected %s", show(want));
               $display("  actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [7:0]  req_symbol_id;
   logic [47:0] req_time_ms;
   logic [31:0] req_price;
   logic [31:0] req_quantity;
   logic        req_buyer_is_maker;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_symbol;
   logic [47:0] rsp_out_window_start;
   logic [31:0] rsp_lo_price;
   logic [31:0] rsp_hi_price;
   logic [31:0] rsp_n_trades;
   logic [63:0] rsp_notional;
   logic [31:0] rsp_buyer_count;
   logic [31:0] rsp_seller_count;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [26:0] csr_data;

   window_table_scoreboard sb = new();
   int   idle_cycles = 0;
   bit   no_gaps;
   logic [47:0] phase_base;

   always #4 clock = ~clock;

   windowed_trade_stats_table_core #(.TABLE_ENTRIES(N_SLOTS)) dut (.*);

   // Monitor: the response beat is checked before a request beat taken at
   // the same edge is noted, since the response belongs to the older request.
   // A window length written at the same edge already applies to that request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_beat({rsp_status, rsp_out_symbol, rsp_out_window_start,
                           rsp_lo_price, rsp_hi_price, rsp_n_trades,
                           rsp_notional, rsp_buyer_count, rsp_seller_count, rsp_last});
         if (csr_valid && csr_ready)
            sb.win_len = csr_data;
         if (start && !busy)
            sb.note_request(req_command, req_symbol_id, req_time_ms, req_price,
                            req_quantity, req_buyer_is_maker);
         // Watchdog: any beat on any channel counts as progress.
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Presents one request until taken, then drops start for a random gap unless
   // no_gaps; with no gap it stays high so a back-to-back request needs no toggle.
   task automatic issue(logic [1:0] cmd, logic [7:0] sym, logic [47:0] t,
                        logic [31:0] price, logic [31:0] qty, logic seller);
      int gap;
      req_command        <= cmd;
      req_symbol_id      <= sym;
      req_time_ms        <= t;
      req_price          <= price;
      req_quantity       <= qty;
      req_buyer_is_maker <= seller;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits for every expected beat and lets the block settle before the
   // window length may change. The first edge lets the monitor note the
   // request taken at the current edge.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_window_len(logic [26:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [47:0] rand_time48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Trade near the phase base so that windows are shared and updated.
   task automatic random_trade();
      logic [7:0] sym;
      sym = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3) * 85);
      issue(CMD_TRADE, sym, phase_base + 48'($urandom_range(0, 3 * (sb.win_len + 1))),
            $urandom, $urandom, 1'($urandom));
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         random_trade();
      else if (pick < 80) begin
         if ($urandom_range(0, 1))
            issue(CMD_QUERY, sb.recent_symbol, sb.recent_window, $urandom, $urandom,
                  1'($urandom));
         else
            issue(CMD_QUERY, 8'($urandom), rand_time48(), $urandom, $urandom,
                  1'($urandom));
      end else if (pick < 92)
         issue(CMD_EXT_DONE, 8'($urandom),
               phase_base + 48'($urandom_range(0, 3 * (sb.win_len + 1))),
               $urandom, $urandom, 1'($urandom));
      else
         issue(CMD_EXT_ALL, 8'($urandom), rand_time48(), $urandom, $urandom,
               1'($urandom));
   endtask

   initial begin
      logic [26:0] lengths[6];
      start <= 1'b0;
      req_command <= CMD_TRADE;
      req_symbol_id <= '0;
      req_time_ms <= '0;
      req_price <= '0;
      req_quantity <= '0;
      req_buyer_is_maker <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      no_gaps = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset window length of one second.
      issue(CMD_EXT_ALL, 8'd0, 48'd0, '0, '0, 1'b0);          // empty table
      issue(CMD_TRADE, 8'd0, 48'd0, 32'd0, 32'd0, 1'b0);
      issue(CMD_TRADE, 8'd255, '1, '1, '1, 1'b1);              // field extremes
      issue(CMD_TRADE, 8'd255, '1, '1, '1, 1'b0);              // notional saturates
      issue(CMD_TRADE, 8'd255, 48'hFFFF_FFFF_FFF0, 32'd5, 32'd2, 1'b1);
      issue(CMD_TRADE, 8'd7, 48'd1999, 32'd100, 32'd3, 1'b0);
      issue(CMD_TRADE, 8'd7, 48'd1000, 32'd50, 32'd4, 1'b1);   // same window, new low
      issue(CMD_TRADE, 8'd7, 48'd1500, 32'd200, 32'd1, 1'b0);  // new high
      issue(CMD_TRADE, 8'd7, 48'd2000, 32'd10, 32'd10, 1'b1);  // next window
      issue(CMD_QUERY, 8'd7, 48'd1000, '1, '1, 1'b1);          // found
      issue(CMD_QUERY, 8'd7, 48'd1001, '0, '0, 1'b0);          // not found
      issue(CMD_QUERY, 8'd255, 48'hFFFF_FFFF_FC18, '0, '0, 1'b0);
      issue(CMD_EXT_DONE, 8'd0, 48'd2000, '0, '0, 1'b0);       // strictly older only
      issue(CMD_EXT_DONE, 8'd0, 48'd0, '0, '0, 1'b0);          // nothing older
      issue(CMD_EXT_ALL, 8'd0, 48'd0, '0, '0, 1'b0);
      drain();

      // Fill the table with distinct symbols, then two more trades are dropped.
      no_gaps = 1;
      for (int i = 0; i <= N_SLOTS; i++)
         issue(CMD_TRADE, 8'(i * 7), rand_time48(), $urandom, $urandom, 1'($urandom));
      no_gaps = 0;
      issue(CMD_TRADE, 8'd1, 48'd5, 32'd1, 32'd1, 1'b0);
      issue(CMD_EXT_ALL, 8'd0, 48'd0, '0, '0, 1'b0);
      drain();

      // Random phases across window lengths, the extremes among them.
      lengths = '{27'd0, 27'd1, 27'h7FF_FFFF, 27'd86400000, 27'd7, 27'($urandom)};
      foreach (lengths[p]) begin
         write_window_len(lengths[p]);
         no_gaps = ($urandom_range(0, 2) == 0);
         phase_base = {1'b0, 47'(rand_time48())};
         repeat (9) random_item();
         issue(CMD_EXT_ALL, 8'd0, 48'd0, '0, '0, 1'b0);
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
